>>> hdl/mart_pkg.sv
// Shared types and codes for the multicast ack retransmit tracker.
package mart_pkg;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;

    localparam logic [3:0] K_PUSH_OK   = 4'd0;
    localparam logic [3:0] K_FULL      = 4'd1;
    localparam logic [3:0] K_SEND      = 4'd2;
    localparam logic [3:0] K_SERVICED  = 4'd3;
    localparam logic [3:0] K_DELIVERED = 4'd4;
    localparam logic [3:0] K_FAILED    = 4'd5;
    localparam logic [3:0] K_ACK_HIT   = 4'd6;
    localparam logic [3:0] K_ACK_MISS  = 4'd7;
    localparam logic [3:0] K_EMPTY     = 4'd8;

    localparam logic [1:0] PH_NEW     = 2'd0;
    localparam logic [1:0] PH_STARTED = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;
    localparam logic [1:0] PH_FAILED  = 2'd3;

    localparam logic [2:0] REG_DEST_COUNT = 3'd0;
    localparam logic [2:0] REG_TIMEOUT    = 3'd1;
    localparam logic [2:0] REG_MAX_ATT    = 3'd2;
    localparam logic [2:0] REG_IP_A       = 3'd3;
    localparam logic [2:0] REG_IP_B       = 3'd4;
    localparam logic [2:0] REG_IP_C       = 3'd5;
    localparam logic [2:0] REG_IP_D       = 3'd6;

    localparam int IP_REGS = 4;

    typedef struct packed {
        logic [2:0]               dest_count;
        logic [15:0]              retry_timeout_ms;
        logic [7:0]               max_attempts;
        logic [IP_REGS-1:0][31:0] dest_ip;
    } mart_cfg_t;

endpackage

>>> hdl/mart_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module mart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/mart_ctrl.sv
// Sequencer: list order, entry and destination memories, result register.
module mart_ctrl
    import mart_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int MAX_DESTS  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  mart_cfg_t   cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  in_opcode,
    input  logic [31:0] in_now,
    input  logic [31:0] in_sum,
    input  logic [31:0] in_ip,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tlast,
    output logic [3:0]  out_kind,
    output logic [31:0] out_sum,
    output logic [1:0]  out_dest,
    output logic [4:0]  out_pending,
    output logic [15:0] out_miss,
    output logic [15:0] out_ack
);

    localparam int IW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW  = $clog2(LIST_DEPTH + 1);
    localparam int DCW = $clog2(MAX_DESTS + 1);
    localparam int DW  = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;
    localparam int AW  = (LIST_DEPTH * MAX_DESTS > 1) ? $clog2(LIST_DEPTH * MAX_DESTS) : 1;
    localparam int EW  = 34 + MAX_DESTS;
    localparam int NW  = 3;

    typedef enum logic [3:0] {
        S_IDLE, S_T_ENT, S_T_CAP, S_T_RD, S_T_WR, S_T_FIN, S_T_SEND,
        S_P_CLR, S_A_RD, S_A_CHK, S_EMIT
    } state_t;

    state_t state_reg;
    logic [IW-1:0]        order_reg [LIST_DEPTH];
    logic [CW-1:0]        total_reg;
    logic [IW-1:0]        pos_reg;
    logic [15:0]          miss_reg, ack_reg;
    logic [31:0]          now_reg, sum_reg, ip_reg;
    logic [IW-1:0]        idx_reg, slot_reg;
    logic [DCW-1:0]       d_reg;
    logic [MAX_DESTS-1:0] due_reg, flags_reg;
    logic [1:0]           phase_reg;
    logic                 fail_reg;
    logic [3:0]           pk_reg;
    logic [31:0]          psum_reg;
    logic                 ovalid_reg, olast_reg;
    logic [3:0]           okind_reg;
    logic [31:0]          osum_reg;
    logic [1:0]           odest_reg;
    logic [4:0]           opend_reg;
    logic [15:0]          omiss_reg, oack_reg;

    logic           ent_we, dst_we;
    logic [IW-1:0]  ent_waddr, ent_raddr;
    logic [EW-1:0]  ent_wdata, ent_rdata;
    logic [AW-1:0]  dst_waddr, dst_raddr, dst_addr;
    logic [39:0]    dst_wdata, dst_rdata;

    logic [NW-1:0]  nd;
    logic           out_free;
    logic           out_load;
    logic [IW-1:0]  tick_idx;
    logic [31:0]    dt;
    logic [7:0]     att_inc;
    logic           due_now;
    logic [1:0]     fin_phase;
    logic [MAX_DESTS-1:0] fin_flags, live_mask, ack_flags;
    logic           ack_found;
    logic [DW-1:0]  ack_d;
    logic [CW-1:0]  total_dec;
    logic [CW-1:0]  idx_inc;

    always_comb begin
        nd = (cfg.dest_count == 3'd0) ? 3'd1 : cfg.dest_count;
        if (int'(nd) > MAX_DESTS) nd = NW'(MAX_DESTS);
        if (int'(nd) > IP_REGS) nd = NW'(IP_REGS);
    end

    always_comb begin
        for (int j = 0; j < MAX_DESTS; j++) begin
            live_mask[j] = (j < int'(nd));
        end
    end

    assign out_free = !ovalid_reg || m_tready;
    // a beat enters the output register on a due send or on the closing beat
    assign out_load = out_free &&
                      ((state_reg == S_EMIT) ||
                       (state_reg == S_T_SEND && d_reg < DCW'(nd) &&
                        due_reg[d_reg[DW-1:0]]));
    assign tick_idx = (CW'(pos_reg) < total_reg) ? pos_reg : '0;
    assign dst_addr = AW'(int'(slot_reg) * MAX_DESTS + int'(d_reg));
    assign dt       = now_reg - dst_rdata[39:8];
    assign att_inc  = (dst_rdata[7:0] == 8'hFF) ? 8'hFF : dst_rdata[7:0] + 8'd1;
    assign due_now  = !flags_reg[d_reg[DW-1:0]] && (dt > {16'd0, cfg.retry_timeout_ms});
    assign total_dec = total_reg - CW'(1);
    assign idx_inc  = CW'(idx_reg) + CW'(1);

    // first configured destination whose address matches the sender
    always_comb begin
        ack_found = 1'b0;
        ack_d     = '0;
        for (int j = IP_REGS - 1; j >= 0; j--) begin
            if (j < int'(nd) && cfg.dest_ip[j] == ip_reg) begin
                ack_found = 1'b1;
                ack_d     = DW'(j);
            end
        end
    end

    always_comb begin
        ack_flags = ent_rdata[MAX_DESTS-1:0];
        if (ack_found) ack_flags[ack_d] = 1'b1;
    end

    always_comb begin
        fin_phase = phase_reg;
        fin_flags = flags_reg;
        case (phase_reg)
            PH_NEW: begin
                fin_phase = PH_STARTED;
                fin_flags = flags_reg & ~live_mask;
            end
            PH_STARTED: fin_phase = fail_reg ? PH_FAILED : PH_STARTED;
            default: fin_phase = phase_reg;
        endcase
    end

    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = slot_reg;
        ent_wdata = {sum_reg, PH_NEW, {MAX_DESTS{1'b0}}};
        dst_we    = 1'b0;
        dst_waddr = dst_addr;
        dst_wdata = '0;
        ent_raddr = slot_reg;
        dst_raddr = dst_addr;
        case (state_reg)
            S_T_FIN: begin
                ent_we    = 1'b1;
                ent_wdata = {psum_reg, fin_phase, fin_flags};
            end
            S_T_WR: begin
                dst_we    = (phase_reg == PH_NEW) || due_now;
                dst_wdata = {now_reg, att_inc};
            end
            S_P_CLR: begin
                ent_we = (d_reg == '0);
                dst_we = 1'b1;
            end
            S_A_CHK: begin
                ent_we    = (ent_rdata[EW-1:MAX_DESTS+2] == sum_reg);
                ent_waddr = order_reg[idx_reg];
                ent_wdata = {sum_reg,
                             (ack_found && &(ack_flags | ~live_mask)) ?
                                 PH_DONE : ent_rdata[MAX_DESTS+1:MAX_DESTS],
                             ack_flags};
            end
            S_A_RD: ent_raddr = order_reg[idx_reg];
            default: ;
        endcase
    end

    mart_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH), .AW(IW)) u_ent (
        .aclk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    mart_ram #(.WIDTH(40), .DEPTH(LIST_DEPTH * MAX_DESTS), .AW(AW)) u_dst (
        .aclk(aclk), .we(dst_we), .waddr(dst_waddr), .wdata(dst_wdata),
        .raddr(dst_raddr), .rdata(dst_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            pos_reg    <= '0;
            miss_reg   <= '0;
            ack_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < LIST_DEPTH; i++) begin
                order_reg[i] <= IW'(i);
            end
        end else begin
            if (out_load) begin
                ovalid_reg <= 1'b1;
                opend_reg  <= 5'(total_reg);
                omiss_reg  <= miss_reg;
                oack_reg   <= ack_reg;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        now_reg <= in_now;
                        sum_reg <= in_sum;
                        ip_reg  <= in_ip;
                        psum_reg <= (in_opcode == OP_TICK) ? 32'd0 : in_sum;
                        d_reg   <= '0;
                        idx_reg <= (in_opcode == OP_TICK) ? tick_idx : '0;
                        case (in_opcode)
                            OP_TICK: begin
                                if (total_reg == '0) begin
                                    pk_reg    <= K_EMPTY;
                                    state_reg <= S_EMIT;
                                end else begin
                                    slot_reg  <= order_reg[tick_idx];
                                    state_reg <= S_T_ENT;
                                end
                            end
                            OP_PUSH: begin
                                if (total_reg >= CW'(LIST_DEPTH)) begin
                                    pk_reg    <= K_FULL;
                                    state_reg <= S_EMIT;
                                end else begin
                                    slot_reg  <= order_reg[total_reg[IW-1:0]];
                                    state_reg <= S_P_CLR;
                                end
                            end
                            OP_ACK: begin
                                if (total_reg == '0) begin
                                    pk_reg    <= K_ACK_MISS;
                                    state_reg <= S_EMIT;
                                end else begin
                                    state_reg <= S_A_RD;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_T_ENT: state_reg <= S_T_CAP;
                S_T_CAP: begin
                    psum_reg  <= ent_rdata[EW-1:MAX_DESTS+2];
                    phase_reg <= ent_rdata[MAX_DESTS+1:MAX_DESTS];
                    flags_reg <= ent_rdata[MAX_DESTS-1:0];
                    due_reg   <= '0;
                    fail_reg  <= 1'b0;
                    if (ent_rdata[MAX_DESTS+1:MAX_DESTS] == PH_NEW ||
                        ent_rdata[MAX_DESTS+1:MAX_DESTS] == PH_STARTED) begin
                        state_reg <= S_T_RD;
                    end else begin
                        state_reg <= S_T_FIN;
                    end
                end
                S_T_RD: state_reg <= S_T_WR;
                S_T_WR: begin
                    if (phase_reg == PH_NEW) begin
                        due_reg[d_reg[DW-1:0]] <= 1'b1;
                    end else if (due_now) begin
                        due_reg[d_reg[DW-1:0]] <= 1'b1;
                        if (att_inc >= cfg.max_attempts) fail_reg <= 1'b1;
                    end
                    if (int'(d_reg) + 1 < int'(nd)) begin
                        d_reg     <= d_reg + DCW'(1);
                        state_reg <= S_T_RD;
                    end else begin
                        state_reg <= S_T_FIN;
                    end
                end
                S_T_FIN: begin
                    d_reg <= '0;
                    if (fin_phase == PH_DONE || fin_phase == PH_FAILED) begin
                        // close the gap and park the freed slot at the tail
                        for (int i = 0; i < LIST_DEPTH; i++) begin
                            if (i >= int'(idx_reg)) begin
                                if (i == LIST_DEPTH - 1) order_reg[i] <= order_reg[idx_reg];
                                else order_reg[i] <= order_reg[(i + 1) % LIST_DEPTH];
                            end
                        end
                        total_reg <= total_dec;
                        pos_reg   <= (idx_inc >= total_dec) ? '0 : idx_inc[IW-1:0];
                        if (fin_phase == PH_FAILED) begin
                            miss_reg <= miss_reg + 16'd1;
                            pk_reg   <= K_FAILED;
                        end else begin
                            pk_reg   <= K_DELIVERED;
                        end
                    end else begin
                        pos_reg <= (idx_inc >= total_reg) ? '0 : idx_inc[IW-1:0];
                        pk_reg  <= K_SERVICED;
                    end
                    state_reg <= S_T_SEND;
                end
                S_T_SEND: begin
                    if (d_reg >= DCW'(nd)) begin
                        state_reg <= S_EMIT;
                    end else if (!due_reg[d_reg[DW-1:0]]) begin
                        d_reg <= d_reg + DCW'(1);
                    end else if (out_free) begin
                        olast_reg  <= 1'b0;
                        okind_reg  <= K_SEND;
                        osum_reg   <= psum_reg;
                        odest_reg  <= 2'(d_reg);
                        d_reg      <= d_reg + DCW'(1);
                    end
                end
                S_P_CLR: begin
                    if (int'(d_reg) + 1 < MAX_DESTS) begin
                        d_reg <= d_reg + DCW'(1);
                    end else begin
                        total_reg <= total_reg + CW'(1);
                        pk_reg    <= K_PUSH_OK;
                        state_reg <= S_EMIT;
                    end
                end
                S_A_RD: state_reg <= S_A_CHK;
                S_A_CHK: begin
                    if (ent_rdata[EW-1:MAX_DESTS+2] == sum_reg) begin
                        ack_reg   <= ack_reg + 16'd1;
                        pk_reg    <= K_ACK_HIT;
                        state_reg <= S_EMIT;
                    end else if (idx_inc >= total_reg) begin
                        pk_reg    <= K_ACK_MISS;
                        state_reg <= S_EMIT;
                    end else begin
                        idx_reg   <= idx_inc[IW-1:0];
                        state_reg <= S_A_RD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        olast_reg  <= 1'b1;
                        okind_reg  <= pk_reg;
                        osum_reg   <= psum_reg;
                        odest_reg  <= 2'd0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = ovalid_reg;
    assign m_tlast     = olast_reg;
    assign out_kind    = okind_reg;
    assign out_sum     = osum_reg;
    assign out_dest    = odest_reg;
    assign out_pending = opend_reg;
    assign out_miss    = omiss_reg;
    assign out_ack     = oack_reg;

endmodule

>>> hdl/multicast_ack_retransmit_tracker.sv
// A push clears the entry and destination records of its slot; a refused push and an ack
// on an empty list answer at once; an ack walks the entries in list order until a match.
// A tick checks each destination in turn, then sends to the due ones before its last beat.
// One item in flight; the next beat is taken in the cycle after the last result is loaded.
// Reset (aresetn low, synchronous) empties the list and clears counters and config to defaults.
// RAM contents are not cleared; a push initializes its entry.
module multicast_ack_retransmit_tracker
    import mart_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int MAX_DESTS  = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // now_ms, packet_sum, sender_ip
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tlast,
    output logic [71:0]  m_tdata,   // result_sum, dest_index, pending, miss_total, ack_total, pad
    output logic [3:0]   m_tuser    // kind
);

    mart_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_count       <= 3'd1;
            cfg_reg.retry_timeout_ms <= 16'd1000;
            cfg_reg.max_attempts     <= 8'd3;
            cfg_reg.dest_ip          <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEST_COUNT: cfg_reg.dest_count       <= cfg_wdata[2:0];
                REG_TIMEOUT:    cfg_reg.retry_timeout_ms <= cfg_wdata[15:0];
                REG_MAX_ATT:    cfg_reg.max_attempts     <= cfg_wdata[7:0];
                REG_IP_A:       cfg_reg.dest_ip[0]       <= cfg_wdata;
                REG_IP_B:       cfg_reg.dest_ip[1]       <= cfg_wdata;
                REG_IP_C:       cfg_reg.dest_ip[2]       <= cfg_wdata;
                REG_IP_D:       cfg_reg.dest_ip[3]       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [31:0] o_sum;
    logic [1:0]  o_dest;
    logic [4:0]  o_pend;
    logic [15:0] o_miss, o_ack;

    mart_ctrl #(.LIST_DEPTH(LIST_DEPTH), .MAX_DESTS(MAX_DESTS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_opcode(s_tuser), .in_now(s_tdata[31:0]),
        .in_sum(s_tdata[63:32]), .in_ip(s_tdata[95:64]),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
        .out_kind(m_tuser), .out_sum(o_sum), .out_dest(o_dest),
        .out_pending(o_pend), .out_miss(o_miss), .out_ack(o_ack)
    );

    assign m_tdata = {1'b0, o_ack, o_miss, o_pend, o_dest, o_sum};

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the multicast ack retransmit tracker.
`timescale 1ns / 100ps

module tb;
    import mart_pkg::*;

    localparam int DEPTH     = 16;
    localparam int NDEST     = 4;
    localparam int CYC_LIMIT = 400000;
    localparam int DRAIN     = 60;
    localparam logic [1:0] OP_RSVD = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [31:0] sum;
        logic [31:0] ip;
    } pkt_req_t;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] sum;
        logic [1:0]  dest;
        logic        last;
        logic [4:0]  pending;
        logic [15:0] miss;
        logic [15:0] acks;
    } tracker_evt_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // now_ms, packet_sum, sender_ip
    logic [1:0]  s_tuser = '0;   // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        m_tlast;
    logic [71:0] m_tdata;        // result_sum, dest_index, pending, miss_total, ack_total, pad
    logic [3:0]  m_tuser;        // kind

    multicast_ack_retransmit_tracker u_top (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // shadow of the tracker state
    logic [2:0]  sh_dest_count = 3'd1;
    logic [15:0] sh_timeout = 16'd1000;
    logic [7:0]  sh_max_att = 8'd3;
    logic [31:0] sh_ip [NDEST] = '{default: '0};
    logic [31:0] ent_sum [DEPTH];
    logic [1:0]  ent_phase [DEPTH];
    logic [31:0] ent_sent [DEPTH][NDEST];
    logic [7:0]  ent_att [DEPTH][NDEST];
    logic        ent_acked [DEPTH][NDEST];
    int          ent_total = 0;
    int          svc_pos = 0;
    logic [15:0] miss_cnt = '0;
    logic [15:0] hit_cnt = '0;

    pkt_req_t     req_q [$];
    tracker_evt_t evt_q [$];
    int           errors = 0;
    int           n_items = 0;
    int           n_beats = 0;
    int           n_sends = 0;
    int           cycles = 0;

    function automatic int active_dests();
        int n;
        n = sh_dest_count;
        if (n == 0) n = 1;
        if (n > NDEST) n = NDEST;
        return n;
    endfunction

    function automatic void drop_entry(int idx);
        for (int i = idx; i + 1 < ent_total; i++) begin
            ent_sum[i] = ent_sum[i+1];
            ent_phase[i] = ent_phase[i+1];
            for (int d = 0; d < NDEST; d++) begin
                ent_sent[i][d] = ent_sent[i+1][d];
                ent_att[i][d] = ent_att[i+1][d];
                ent_acked[i][d] = ent_acked[i+1][d];
            end
        end
        ent_total--;
    endfunction

    // Work out the beats one accepted request produces and queue them.
    function automatic void track_request(pkt_req_t r);
        tracker_evt_t evs [$];
        tracker_evt_t e;
        int nd;
        int idx;
        logic [31:0] sum;
        bit all;
        nd = active_dests();
        e = '{kind: K_EMPTY, sum: '0, dest: '0, last: 0, pending: '0, miss: '0, acks: '0};
        case (r.op)
            OP_TICK: begin
                if (ent_total == 0) begin
                    evs.push_back(e);
                end else begin
                    idx = (svc_pos < ent_total) ? svc_pos : 0;
                    sum = ent_sum[idx];
                    e.sum = sum;
                    if (ent_phase[idx] == PH_NEW) begin
                        for (int d = 0; d < nd; d++) begin
                            e.kind = K_SEND; e.dest = 2'(d);
                            evs.push_back(e);
                            ent_sent[idx][d] = r.now_ms;
                            if (ent_att[idx][d] != 8'hFF) ent_att[idx][d]++;
                            ent_acked[idx][d] = 1'b0;
                        end
                        ent_phase[idx] = PH_STARTED;
                    end else if (ent_phase[idx] == PH_STARTED) begin
                        for (int d = 0; d < nd; d++) begin
                            if (!ent_acked[idx][d] &&
                                (r.now_ms - ent_sent[idx][d]) > {16'd0, sh_timeout}) begin
                                ent_sent[idx][d] = r.now_ms;
                                if (ent_att[idx][d] != 8'hFF) ent_att[idx][d]++;
                                e.kind = K_SEND; e.dest = 2'(d);
                                evs.push_back(e);
                                if (ent_att[idx][d] >= sh_max_att) ent_phase[idx] = PH_FAILED;
                            end
                        end
                    end
                    e.dest = '0;
                    if (ent_phase[idx] == PH_DONE) begin
                        drop_entry(idx);
                        e.kind = K_DELIVERED;
                    end else if (ent_phase[idx] == PH_FAILED) begin
                        miss_cnt++;
                        drop_entry(idx);
                        e.kind = K_FAILED;
                    end else begin
                        e.kind = K_SERVICED;
                    end
                    evs.push_back(e);
                    idx++;
                    svc_pos = (idx >= ent_total) ? 0 : idx;
                end
            end
            OP_PUSH: begin
                e.sum = r.sum;
                if (ent_total >= DEPTH) begin
                    e.kind = K_FULL;
                end else begin
                    ent_sum[ent_total] = r.sum;
                    ent_phase[ent_total] = PH_NEW;
                    for (int d = 0; d < NDEST; d++) begin
                        ent_sent[ent_total][d] = '0;
                        ent_att[ent_total][d] = '0;
                        ent_acked[ent_total][d] = 1'b0;
                    end
                    ent_total++;
                    e.kind = K_PUSH_OK;
                end
                evs.push_back(e);
            end
            OP_ACK: begin
                e.sum = r.sum;
                e.kind = K_ACK_MISS;
                for (int i = 0; i < ent_total; i++) begin
                    if (ent_sum[i] == r.sum) begin
                        hit_cnt++;
                        e.kind = K_ACK_HIT;
                        for (int d = 0; d < nd; d++) begin
                            if (sh_ip[d] == r.ip) begin
                                ent_acked[i][d] = 1'b1;
                                all = 1;
                                for (int j = 0; j < nd; j++)
                                    if (!ent_acked[i][j]) all = 0;
                                if (all) ent_phase[i] = PH_DONE;
                                break;
                            end
                        end
                        break;
                    end
                end
                evs.push_back(e);
            end
            default: ;  // unused opcode: no beats
        endcase
        foreach (evs[k]) begin
            evs[k].last = (k == evs.size() - 1);
            evs[k].pending = ent_total[4:0];
            evs[k].miss = miss_cnt;
            evs[k].acks = hit_cnt;
            evt_q.push_back(evs[k]);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input driver
    bit s_taken = 0;
    int s_gap = 0;
    always @(negedge aclk) begin
        if (s_tvalid && !s_taken) begin
            // hold the beat
        end else if (s_gap > 0) begin
            s_gap <= s_gap - 1;
            s_tvalid <= 1'b0;
        end else if (aresetn && req_q.size() > 0) begin
            pkt_req_t r;
            r = req_q.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= r.op;
            s_tdata <= {r.ip, r.sum, r.now_ms};
            s_gap <= pick_gap();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    int m_gap = 0;
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            m_gap <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        end
    end

    // accept requests and check result beats
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        s_taken = aresetn && s_tvalid && s_tready;
        if (s_taken) begin
            track_request('{op: s_tuser, now_ms: s_tdata[31:0], sum: s_tdata[63:32],
                            ip: s_tdata[95:64]});
            n_items++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_beats++;
            if (m_tuser == K_SEND) n_sends++;
            if (evt_q.size() == 0) begin
                $error("unexpected beat kind=%0d sum=%h", m_tuser, m_tdata[31:0]);
                errors++;
            end else begin
                tracker_evt_t x;
                x = evt_q.pop_front();
                if (m_tuser !== x.kind) begin
                    $error("kind: expected %0d actual %0d", x.kind, m_tuser); errors++;
                end
                if (m_tdata[31:0] !== x.sum) begin
                    $error("result_sum: expected %h actual %h", x.sum, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[33:32] !== x.dest) begin
                    $error("dest_index: expected %0d actual %0d", x.dest, m_tdata[33:32]);
                    errors++;
                end
                if (m_tlast !== x.last) begin
                    $error("last: expected %0d actual %0d", x.last, m_tlast); errors++;
                end
                if (m_tdata[38:34] !== x.pending) begin
                    $error("pending: expected %0d actual %0d", x.pending, m_tdata[38:34]);
                    errors++;
                end
                if (m_tdata[54:39] !== x.miss) begin
                    $error("miss_total: expected %0d actual %0d", x.miss, m_tdata[54:39]);
                    errors++;
                end
                if (m_tdata[70:55] !== x.acks) begin
                    $error("ack_total: expected %0d actual %0d", x.acks, m_tdata[70:55]);
                    errors++;
                end
            end
        end
    end

    // stimulus
    logic [31:0] clk_ms;
    logic [31:0] sum_pool [8];

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DEST_COUNT: sh_dest_count = val[2:0];
            REG_TIMEOUT:    sh_timeout = val[15:0];
            REG_MAX_ATT:    sh_max_att = val[7:0];
            REG_IP_A:       sh_ip[0] = val;
            REG_IP_B:       sh_ip[1] = val;
            REG_IP_C:       sh_ip[2] = val;
            REG_IP_D:       sh_ip[3] = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (req_q.size() > 0 || s_tvalid || evt_q.size() > 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic setup(logic [2:0] dc, logic [15:0] tmo, logic [7:0] att);
        write_reg(REG_DEST_COUNT, {29'd0, dc});
        write_reg(REG_TIMEOUT, {16'd0, tmo});
        write_reg(REG_MAX_ATT, {24'd0, att});
        write_reg(REG_IP_A, $urandom);
        write_reg(REG_IP_B, $urandom);
        write_reg(REG_IP_C, ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF);
        write_reg(REG_IP_D, $urandom);
        foreach (sum_pool[i]) sum_pool[i] = $urandom;
    endtask

    function automatic void add_req(logic [1:0] op, logic [31:0] sum, logic [31:0] ip);
        req_q.push_back('{op: op, now_ms: clk_ms, sum: sum, ip: ip});
    endfunction

    function automatic void add_random();
        int r;
        logic [1:0] op;
        logic [31:0] sum;
        logic [31:0] ip;
        r = $urandom_range(0, 99);
        // advance time: mostly small steps, now and then a big jump
        clk_ms += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 120);
        op = (r < 40) ? OP_TICK : (r < 68) ? OP_PUSH : (r < 95) ? OP_ACK : OP_RSVD;
        sum = ($urandom_range(0, 9) == 0) ? $urandom : sum_pool[$urandom_range(0, 7)];
        ip = ($urandom_range(0, 3) == 0) ? $urandom : sh_ip[$urandom_range(0, NDEST - 1)];
        add_req(op, sum, ip);
    endfunction

    initial begin
        clk_ms = 32'hFFFF_FF00;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        setup(3'd4, 16'd50, 8'd3);
        // directed: empty tick, unused opcode, extreme sums, fill past full
        add_req(OP_TICK, 32'h0, 32'h0);
        add_req(OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(OP_ACK, 32'h1234_5678, sh_ip[0]);
        add_req(OP_PUSH, 32'h0, 32'h0);
        add_req(OP_PUSH, 32'hFFFF_FFFF, 32'h0);
        add_req(OP_ACK, 32'h0, 32'hDEAD_BEEF);
        for (int i = 0; i < 4; i++) add_req(OP_ACK, 32'hFFFF_FFFF, sh_ip[i]);
        for (int i = 0; i < 15; i++) add_req(OP_PUSH, sum_pool[i % 8], 32'h0);
        add_req(OP_TICK, 32'h0, 32'h0);
        add_req(OP_TICK, 32'h0, 32'h0);
        clk_ms += 200;
        add_req(OP_TICK, 32'h0, 32'h0);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: setup(3'd1, 16'd0, 8'd1);
                1: setup(3'd0, 16'd30, 8'd0);
                2: setup(3'd7, 16'hFFFF, 8'hFF);
                3: setup(3'd2, 16'd100, 8'd2);
                4: setup(3'd3, 16'd20, 8'd5);
                default: setup(3'd4, 16'd60, 8'd3);
            endcase
            for (int i = 0; i < 27; i++) add_random();
            wait_idle();
        end

        $display("Covered %0d requests and %0d result beats (%0d sends) over seven settings.",
                 n_items, n_beats, n_sends);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
